[rtl/bsrc_pkg.sv]
// Package: shared types and constants of the banker's algorithm engine.
`default_nettype none
package bsrc_pkg;
  localparam int MaxProcs = 8;
  localparam int MaxRes = 4;
  localparam int CountWidth = 16;
  localparam int PW = $clog2(MaxProcs);
  localparam int RW = $clog2(MaxRes);
  localparam int WorkWidth = CountWidth + PW + 1;

  typedef enum logic [1:0] {
    REQ_LOAD_PROC = 2'd0,
    REQ_LOAD_AVAIL = 2'd1,
    REQ_ELEMENT = 2'd2,
    REQ_CHECK = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_LOADED = 3'd0,
    ST_LOAD_REJ = 3'd1,
    ST_SAFE = 3'd2,
    ST_UNSAFE = 3'd3,
    ST_GRANTED = 3'd4,
    ST_EXC_NEED = 3'd5,
    ST_EXC_AVAIL = 3'd6,
    ST_DENIED = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CFG_NUM_PROCS = 2'd0,
    CFG_NUM_RES = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_NEED, S_CHK_AVAIL, S_GRANT, S_SCAN_INIT, S_SCAN_TEST,
    S_SCAN_ADD, S_SCAN_END, S_ROLLBACK, S_EMIT, S_OUT_WAIT
  } fsm_e;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_process;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  process_index;
    logic [1:0]  resource_index;
    logic [15:0] max_claim;
    logic [15:0] amount;
    logic        last;
  } item_t;
endpackage
`default_nettype wire

[rtl/bsrc_if.sv]
// Interfaces: valid/ready channels for input words and result words.
`default_nettype none
interface bsrc_in_if;
  import bsrc_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bsrc_out_if;
  import bsrc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/bsrc_cmp.sv]
// Shared unit: one compare and one add or subtract per cycle.
`default_nettype none
module bsrc_cmp (
  input  wire logic [bsrc_pkg::WorkWidth-1:0] a_i,
  input  wire logic [bsrc_pkg::WorkWidth-1:0] b_i,
  input  wire logic                           sub_i,
  output logic                                gt_o,
  output logic [bsrc_pkg::WorkWidth-1:0]      sum_o
);
  import bsrc_pkg::*;
  assign gt_o = a_i > b_i;
  assign sum_o = sub_i ? a_i - b_i : a_i + b_i;
endmodule
`default_nettype wire

[rtl/bankers_safety_and_request_check.sv]
// Top level: banker's algorithm engine with a sequenced shared compare/add unit.
// A request or check scans one resource per cycle.
// Results leave at one word a cycle while out_if.ready allows, from an output register; one item at a time.
// Asynchronous active-low reset clears tables (held, need, available) to zero,
// and the configuration to 8 processes and 4 resources.
`default_nettype none
module bankers_safety_and_request_check (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [3:0] cfg_data_i,
  bsrc_in_if.sink         in_if,
  bsrc_out_if.source      out_if
);
  import bsrc_pkg::*;
  localparam int WW = WorkWidth;
  localparam int CW = CountWidth;

  fsm_e state_q, state_d;
  logic [3:0] nproc_q;
  logic [2:0] nres_q;
  logic [CW-1:0] avail_q [MaxRes];
  logic [CW-1:0] held_q [MaxProcs*MaxRes];
  logic [CW-1:0] need_q [MaxProcs*MaxRes];
  logic [CW-1:0] rbuf_q [MaxRes];
  logic [WW-1:0] work_q [MaxRes];
  logic [MaxProcs-1:0] fin_q;
  logic [PW-1:0] seq_q [MaxProcs];
  logic [PW:0] done_q, emit_q;
  logic [PW-1:0] p_q, req_p_q;
  logic [RW-1:0] r_q;
  logic fits_q, is_req_q;
  result_t res_q;
  logic ovalid_q;

  logic [PW:0] np;
  logic [RW:0] nr;
  logic [RW-1:0] nr_last;
  logic [PW-1:0] np_last;
  logic [WW-1:0] a, b, sum;
  logic sub, gt;
  logic [PW+RW-1:0] pr_idx, rq_idx;
  logic accept;
  item_t it;
  status_e acc_status;

  assign it = in_if.data;
  assign np = (nproc_q == 4'd0) ? (PW+1)'(1) :
              (nproc_q > 4'(MaxProcs)) ? (PW+1)'(MaxProcs) : (PW+1)'(nproc_q);
  assign nr = (nres_q == 3'd0) ? (RW+1)'(1) :
              (nres_q > 3'(MaxRes)) ? (RW+1)'(MaxRes) : (RW+1)'(nres_q);
  assign nr_last = RW'(nr - (RW+1)'(1));
  assign np_last = PW'(np - (PW+1)'(1));
  assign pr_idx = {p_q, r_q};
  assign rq_idx = {req_p_q, r_q};
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data = res_q;
  assign acc_status = (req_type_e'(it.req_type) == REQ_ELEMENT) ? ST_EXC_NEED :
                      ((req_type_e'(it.req_type) == REQ_LOAD_PROC) &&
                       (it.amount > it.max_claim)) ? ST_LOAD_REJ : ST_LOADED;

  always_comb begin
    sub = 1'b0;
    a = '0;
    b = '0;
    case (state_q)
      S_CHK_NEED: begin
        a = WW'(rbuf_q[r_q]);
        b = WW'(need_q[rq_idx]);
      end
      S_CHK_AVAIL: begin
        a = WW'(rbuf_q[r_q]);
        b = WW'(avail_q[r_q]);
      end
      S_SCAN_TEST: begin
        a = WW'(need_q[pr_idx]);
        b = work_q[r_q];
      end
      S_SCAN_ADD: begin
        a = work_q[r_q];
        b = WW'(held_q[pr_idx]);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  bsrc_cmp u_cmp (.a_i(a), .b_i(b), .sub_i(sub), .gt_o(gt), .sum_o(sum));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) begin
        case (req_type_e'(it.req_type))
          REQ_CHECK: state_d = S_SCAN_INIT;
          REQ_ELEMENT: if (it.last) begin
            state_d = ((PW+1)'(it.process_index) >= np) ? S_OUT_WAIT : S_CHK_NEED;
          end
          default: state_d = S_OUT_WAIT;
        endcase
      end
      S_CHK_NEED: state_d = gt ? S_OUT_WAIT : S_CHK_AVAIL;
      S_CHK_AVAIL: state_d = gt ? S_OUT_WAIT : (r_q == nr_last) ? S_GRANT : S_CHK_NEED;
      S_GRANT: state_d = (r_q == nr_last) ? S_SCAN_INIT : S_GRANT;
      S_SCAN_INIT: state_d = S_SCAN_TEST;
      S_SCAN_TEST: begin
        if (fin_q[p_q] || gt) begin
          state_d = (p_q == np_last) ? S_SCAN_END : S_SCAN_TEST;
        end else if (r_q == nr_last) begin
          state_d = S_SCAN_ADD;
        end
      end
      S_SCAN_ADD: if (r_q == nr_last) begin
        state_d = (done_q + (PW+1)'(1) == np) ? S_SCAN_END : S_SCAN_TEST;
      end
      S_SCAN_END: state_d = (done_q == np) ? S_EMIT : (is_req_q ? S_ROLLBACK : S_OUT_WAIT);
      S_ROLLBACK: if (r_q == nr_last) state_d = S_OUT_WAIT;
      S_EMIT: if (!ovalid_q || out_if.ready) begin
        if (emit_q + (PW+1)'(1) == np) state_d = S_OUT_WAIT;
      end
      S_OUT_WAIT: if (!ovalid_q || out_if.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nproc_q <= 4'd8;
      nres_q <= 3'd4;
      ovalid_q <= 1'b0;
      fin_q <= '0;
      for (int i = 0; i < MaxRes; i++) avail_q[i] <= '0;
      for (int i = 0; i < MaxProcs*MaxRes; i++) begin
        held_q[i] <= '0;
        need_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == 1'(CFG_NUM_PROCS)) nproc_q <= cfg_data_i;
        else nres_q <= cfg_data_i[2:0];
      end
      case (state_q)
        S_IDLE: begin
          if (ovalid_q && out_if.ready) ovalid_q <= 1'b0;
          if (accept) begin
            r_q <= '0;
            p_q <= '0;
            emit_q <= '0;
            req_p_q <= it.process_index;
            is_req_q <= (req_type_e'(it.req_type) == REQ_ELEMENT);
            res_q <= '{status: acc_status, seq_process: 3'd0, last_result: 1'b1};
            case (req_type_e'(it.req_type))
              REQ_LOAD_PROC: begin
                if (!(it.amount > it.max_claim)) begin
                  held_q[{it.process_index, it.resource_index}] <= it.amount;
                  need_q[{it.process_index, it.resource_index}] <= it.max_claim - it.amount;
                end
              end
              REQ_LOAD_AVAIL: avail_q[it.resource_index] <= it.amount;
              REQ_ELEMENT: rbuf_q[it.resource_index] <= it.amount;
              default: ;
            endcase
          end
        end
        S_CHK_NEED: if (gt) res_q.status <= ST_EXC_NEED;
        S_CHK_AVAIL: begin
          if (gt) res_q.status <= ST_EXC_AVAIL;
          r_q <= (r_q == nr_last) ? '0 : r_q + RW'(1);
        end
        S_GRANT: begin
          avail_q[r_q] <= avail_q[r_q] - rbuf_q[r_q];
          held_q[rq_idx] <= held_q[rq_idx] + rbuf_q[r_q];
          need_q[rq_idx] <= need_q[rq_idx] - rbuf_q[r_q];
          r_q <= (r_q == nr_last) ? '0 : r_q + RW'(1);
        end
        S_SCAN_INIT: begin
          for (int i = 0; i < MaxRes; i++) work_q[i] <= WW'(avail_q[i]);
          fin_q <= '0;
          done_q <= '0;
          p_q <= '0;
          r_q <= '0;
        end
        S_SCAN_TEST: begin
          if (fin_q[p_q] || gt) begin
            p_q <= p_q + PW'(1);
            r_q <= '0;
          end else begin
            r_q <= (r_q == nr_last) ? '0 : r_q + RW'(1);
          end
        end
        S_SCAN_ADD: begin
          work_q[r_q] <= sum;
          if (r_q == nr_last) begin
            r_q <= '0;
            fin_q[p_q] <= 1'b1;
            seq_q[done_q[PW-1:0]] <= p_q;
            done_q <= done_q + (PW+1)'(1);
            p_q <= '0;
          end else begin
            r_q <= r_q + RW'(1);
          end
        end
        S_SCAN_END: begin
          emit_q <= '0;
          r_q <= '0;
          res_q <= '{status: is_req_q ? ST_DENIED : ST_UNSAFE, seq_process: 3'd0,
                     last_result: 1'b1};
        end
        S_ROLLBACK: begin
          avail_q[r_q] <= avail_q[r_q] + rbuf_q[r_q];
          held_q[rq_idx] <= held_q[rq_idx] - rbuf_q[r_q];
          need_q[rq_idx] <= need_q[rq_idx] + rbuf_q[r_q];
          r_q <= r_q + RW'(1);
        end
        S_EMIT: if (!ovalid_q || out_if.ready) begin
          ovalid_q <= 1'b1;
          res_q <= '{status: is_req_q ? ST_GRANTED : ST_SAFE,
                     seq_process: 3'(seq_q[emit_q[PW-1:0]]),
                     last_result: (emit_q + (PW+1)'(1) == np)};
          emit_q <= emit_q + (PW+1)'(1);
        end
        S_OUT_WAIT: begin
          if (!ovalid_q || out_if.ready) ovalid_q <= !(emit_q != '0 && res_q.last_result);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[sim/bankers_safety_and_request_check_test.sv]
// Testbench: banker's engine driven by a directed table and random request traffic.
`default_nettype none
module bankers_safety_and_request_check_test;
  import bsrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    item_t   it;
    bit      typed;
    status_e st;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [3:0] cfg_data_i;

  bsrc_in_if  in_if ();
  bsrc_out_if out_if ();

  bankers_safety_and_request_check dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  logic [3:0]  procs_reg;
  logic [2:0]  res_reg;
  logic [15:0] avail_cnt [MaxRes];
  logic [15:0] held_tab [MaxProcs][MaxRes];
  logic [15:0] need_tab [MaxProcs][MaxRes];
  logic [15:0] pending_amt [MaxRes];
  result_t     want_q [$];
  int          errors;
  int          burst_left;
  int          rx_cycle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic int procs_in_use();
    if (procs_reg == 0) return 1;
    if (procs_reg > MaxProcs) return MaxProcs;
    return procs_reg;
  endfunction

  function automatic int res_in_use();
    if (res_reg == 0) return 1;
    if (res_reg > MaxRes) return MaxRes;
    return res_reg;
  endfunction

  function automatic item_t mk(req_type_e t, int p, int r, int claim, int amt, bit lst);
    item_t it;
    it.req_type = t;
    it.process_index = p[2:0];
    it.resource_index = r[1:0];
    it.max_claim = claim[15:0];
    it.amount = amt[15:0];
    it.last = lst;
    return it;
  endfunction

  function automatic void push_result(status_e st, int p, bit lst);
    result_t w;
    w.status = st;
    w.seq_process = p[2:0];
    w.last_result = lst;
    want_q.push_back(w);
  endfunction

  // Safety scan: queue the sequence on success, one word of bad_st otherwise.
  function automatic bit scan_and_queue(status_e ok_st, status_e bad_st);
    longint work [MaxRes];
    bit     fin [MaxProcs];
    int     order [MaxProcs];
    int     np, nr, done;
    bit     progress, fits;
    np = procs_in_use();
    nr = res_in_use();
    done = 0;
    progress = 1;
    for (int r = 0; r < nr; r++) work[r] = avail_cnt[r];
    for (int i = 0; i < MaxProcs; i++) fin[i] = 0;
    while (progress && done < np) begin
      progress = 0;
      for (int i = 0; i < np && !progress; i++) begin
        if (!fin[i]) begin
          fits = 1;
          for (int r = 0; r < nr; r++) if (need_tab[i][r] > work[r]) fits = 0;
          if (fits) begin
            fin[i] = 1;
            for (int r = 0; r < nr; r++) work[r] += held_tab[i][r];
            order[done] = i;
            done++;
            progress = 1;
          end
        end
      end
    end
    if (done != np) begin
      push_result(bad_st, 0, 1'b1);
      return 0;
    end
    for (int k = 0; k < np; k++) push_result(ok_st, order[k], k == np - 1);
    return 1;
  endfunction

  function automatic void predict_banker(item_t it);
    int p, r, nr;
    p = it.process_index;
    r = it.resource_index;
    nr = res_in_use();
    case (req_type_e'(it.req_type))
      REQ_LOAD_PROC: begin
        if (it.amount > it.max_claim) begin
          push_result(ST_LOAD_REJ, 0, 1'b1);
        end else begin
          held_tab[p][r] = it.amount;
          need_tab[p][r] = it.max_claim - it.amount;
          push_result(ST_LOADED, 0, 1'b1);
        end
      end
      REQ_LOAD_AVAIL: begin
        avail_cnt[r] = it.amount;
        push_result(ST_LOADED, 0, 1'b1);
      end
      REQ_CHECK: void'(scan_and_queue(ST_SAFE, ST_UNSAFE));
      default: begin
        pending_amt[r] = it.amount;
        if (it.last) begin
          if (p >= procs_in_use()) begin
            push_result(ST_EXC_NEED, 0, 1'b1);
            return;
          end
          for (int i = 0; i < nr; i++) begin
            if (pending_amt[i] > need_tab[p][i]) begin
              push_result(ST_EXC_NEED, 0, 1'b1);
              return;
            end
            if (pending_amt[i] > avail_cnt[i]) begin
              push_result(ST_EXC_AVAIL, 0, 1'b1);
              return;
            end
          end
          for (int i = 0; i < nr; i++) begin
            avail_cnt[i] -= pending_amt[i];
            held_tab[p][i] += pending_amt[i];
            need_tab[p][i] -= pending_amt[i];
          end
          if (!scan_and_queue(ST_GRANTED, ST_DENIED)) begin
            for (int i = 0; i < nr; i++) begin
              avail_cnt[i] += pending_amt[i];
              held_tab[p][i] -= pending_amt[i];
              need_tab[p][i] += pending_amt[i];
            end
          end
        end
      end
    endcase
  endfunction

  task automatic send_word(item_t it, bit typed, status_e st);
    int before_n;
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    before_n = want_q.size();
    predict_banker(it);
    if (typed && want_q.size() == before_n + 1) begin
      void'(want_q.pop_back());
      push_result(st, 0, 1'b1);
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [3:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx[0];
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_PROCS) procs_reg = v;
    else res_reg = v[2:0];
  endtask

  task automatic random_request();
    int p, n, r, amt;
    p = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(procs_in_use() - 1);
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(3);
      case ($urandom_range(9))
        0: amt = $urandom_range(16'hFFFF);
        1: amt = 0;
        default: amt = $urandom_range(need_tab[p & 7][r] < 30 ? need_tab[p & 7][r] + 1 : 30);
      endcase
      send_word(mk(REQ_ELEMENT, p, r, $urandom_range(16'hFFFF), amt, k == n - 1), 0, ST_LOADED);
    end
  endtask

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (want_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %p", $realtime, out_if.data);
        errors++;
      end else begin
        result_t w;
        w = want_q.pop_front();
        if (out_if.data.status !== w.status) begin
          $display("%0t status: expected %0d, actual %0d", $realtime, w.status,
                   out_if.data.status);
          errors++;
        end
        if (out_if.data.seq_process !== w.seq_process) begin
          $display("%0t seq_process: expected %0d, actual %0d", $realtime, w.seq_process,
                   out_if.data.seq_process);
          errors++;
        end
        if (out_if.data.last_result !== w.last_result) begin
          $display("%0t last_result: expected %0d, actual %0d", $realtime, w.last_result,
                   out_if.data.last_result);
          errors++;
        end
      end
    end
  end

  // Stall on a pattern of phases; hold off for a long stretch once.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 1500 && rx_cycle < 2100) out_if.ready <= 1'b0;
    else if ((rx_cycle / 300) % 3 == 0) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(3) != 0);
  end

  initial begin
    row_t rows [$];
    int   settings [6][2];
    int   claim, held, np, nr, op;
    rx_cycle = 0;
    errors = 0;
    burst_left = 4;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    procs_reg = 4'd8;
    res_reg = 3'd4;
    for (int r = 0; r < MaxRes; r++) begin
      avail_cnt[r] = '0;
      pending_amt[r] = '0;
      for (int p = 0; p < MaxProcs; p++) begin
        held_tab[p][r] = '0;
        need_tab[p][r] = '0;
      end
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{mk(REQ_CHECK, 0, 0, 0, 0, 0), 0, ST_SAFE});
    rows.push_back('{mk(REQ_LOAD_PROC, 7, 3, 16'hFFFF, 16'hFFFF, 0), 1, ST_LOADED});
    rows.push_back('{mk(REQ_LOAD_PROC, 7, 3, 16'hFFFF, 0, 1), 1, ST_LOADED});
    rows.push_back('{mk(REQ_LOAD_PROC, 2, 1, 0, 1, 0), 1, ST_LOAD_REJ});
    rows.push_back('{mk(REQ_LOAD_AVAIL, 0, 3, 0, 16'hFFFF, 0), 1, ST_LOADED});
    rows.push_back('{mk(REQ_LOAD_PROC, 0, 0, 10, 2, 0), 1, ST_LOADED});
    rows.push_back('{mk(REQ_LOAD_AVAIL, 0, 0, 0, 5, 0), 1, ST_LOADED});
    rows.push_back('{mk(REQ_CHECK, 5, 2, 16'hFFFF, 16'hFFFF, 1), 0, ST_SAFE});
    rows.push_back('{mk(REQ_ELEMENT, 0, 1, 0, 0, 0), 0, ST_LOADED});
    rows.push_back('{mk(REQ_ELEMENT, 0, 2, 0, 0, 0), 0, ST_LOADED});
    rows.push_back('{mk(REQ_ELEMENT, 0, 3, 0, 0, 0), 0, ST_LOADED});
    rows.push_back('{mk(REQ_ELEMENT, 0, 0, 0, 3, 1), 0, ST_LOADED});
    rows.push_back('{mk(REQ_ELEMENT, 0, 0, 0, 16'hFFFF, 1), 1, ST_EXC_NEED});
    rows.push_back('{mk(REQ_ELEMENT, 0, 0, 0, 6, 1), 1, ST_EXC_AVAIL});
    rows.push_back('{mk(REQ_LOAD_PROC, 1, 1, 100, 0, 0), 1, ST_LOADED});
    rows.push_back('{mk(REQ_CHECK, 0, 0, 0, 0, 0), 1, ST_UNSAFE});
    rows.push_back('{mk(REQ_ELEMENT, 0, 0, 0, 1, 1), 1, ST_DENIED});
    rows.push_back('{mk(REQ_LOAD_PROC, 1, 1, 0, 0, 0), 1, ST_LOADED});
    rows.push_back('{mk(REQ_ELEMENT, 7, 3, 0, 0, 1), 0, ST_LOADED});
    foreach (rows[i]) send_word(rows[i].it, rows[i].typed, rows[i].st);
    drain();
    write_cfg(CFG_NUM_PROCS, 4'd3);
    send_word(mk(REQ_ELEMENT, 5, 0, 0, 0, 1), 1, ST_EXC_NEED);
    drain();

    settings = '{'{8, 4}, '{1, 1}, '{0, 0}, '{15, 7}, '{3, 2}, '{5, 3}};
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_NUM_PROCS, 4'(settings[ph][0]));
      write_cfg(CFG_NUM_RES, 4'(settings[ph][1]));
      np = procs_in_use();
      nr = res_in_use();
      for (int r = 0; r < nr; r++)
        send_word(mk(REQ_LOAD_AVAIL, $urandom_range(7), r, $urandom_range(16'hFFFF),
                     $urandom_range(40), 0), 0, ST_LOADED);
      for (int p = 0; p < np; p++)
        for (int r = 0; r < nr; r++) begin
          claim = ($urandom_range(7) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(20);
          held = ($urandom_range(9) == 0) ? claim + 1 : $urandom_range(claim);
          send_word(mk(REQ_LOAD_PROC, p, r, claim, held, 1'($urandom_range(1))), 0,
                    ST_LOADED);
        end
      for (int k = 0; k < 28; k++) begin
        op = $urandom_range(19);
        if (op < 10) random_request();
        else if (op < 13) send_word(mk(REQ_CHECK, $urandom_range(7), $urandom_range(3),
                                       $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                                       1'($urandom_range(1))), 0, ST_LOADED);
        else if (op < 16) begin
          claim = $urandom_range(20);
          send_word(mk(REQ_LOAD_PROC, $urandom_range(np - 1), $urandom_range(nr - 1), claim,
                       $urandom_range(claim), 0), 0, ST_LOADED);
        end else if (op < 18) send_word(mk(REQ_LOAD_AVAIL, 0, $urandom_range(3), 0,
                                           $urandom_range(60), 0), 0, ST_LOADED);
        else send_word(mk(req_type_e'($urandom_range(1)), $urandom_range(7), $urandom_range(3),
                          $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                          1'($urandom_range(1))), 0, ST_LOADED);
      end
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
